[rtl/kwsm_pkg.sv]
// Shared types, codes and widths for the k-way sorted merge block.
package kwsm_pkg;

	localparam int VALUE_W        = 32;
	localparam int LANE_FIELD_W   = 2;
	localparam int IN_TDATA_W     = 40;
	localparam int OUT_TDATA_W    = 40;
	localparam int STATUS_W       = 2;
	localparam int LANES_DEF      = 4;
	localparam int LANE_DEPTH_DEF = 16;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_TAKE   = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPENDED = 2'd0,
		ST_EMITTED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic append;
		logic scan;
		logic pop;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic opcode;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

[rtl/k_way_sorted_merge.sv]
// Top level of the k-way sorted merge: controller plus datapath.
// Append: the request passes through the APPEND and RESULT states before the next one is taken.
// Take: the head scan visits each lane in turn through the single lane-store read port, then
// the DRAIN, POP and RESULT states follow before the next request is taken.
// One request is in work at a time; a finished result waits in the output register.
// Reset clears all lanes to empty; lane storage itself is not cleared.
module k_way_sorted_merge #(
	parameter int LANES      = kwsm_pkg::LANES_DEF,
	parameter int LANE_DEPTH = kwsm_pkg::LANE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [kwsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // lane[1:0], value[33:2]
	input  logic                               s_axis_tuser,  // opcode[0]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [kwsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // out_value[31:0], source_lane[33:32]
	output logic [kwsm_pkg::STATUS_W-1:0]      m_axis_tuser   // status[1:0]
);
	import kwsm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	kwsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kwsm_dp #(
		.LANES      (LANES),
		.LANE_DEPTH (LANE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[rtl/kwsm_ctrl.sv]
// Controller state machine sequencing append and take requests.
module kwsm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  kwsm_pkg::sts_t  sts,
	output kwsm_pkg::cmd_t  cmd
);
	import kwsm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPEND,
		S_SCAN,
		S_DRAIN,
		S_POP,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign in_ready = ready_q;
	assign accept   = in_valid & ready_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.append = (state_q == S_APPEND);
		cmd.scan   = (state_q == S_SCAN);
		cmd.pop    = (state_q == S_POP);
		cmd.push   = (state_q == S_RESULT) & sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ready_q <= 1'b0;
						state_q <= (sts.opcode == OP_TAKE) ? S_SCAN : S_APPEND;
					end
				end
				S_APPEND: begin
					state_q <= S_RESULT;
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_POP;
				end
				S_POP: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (sts.out_free) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					ready_q <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/kwsm_dp.sv]
// Datapath: lane storage, per-lane pointers, head comparator and result register.
module kwsm_dp #(
	parameter int LANES      = kwsm_pkg::LANES_DEF,
	parameter int LANE_DEPTH = kwsm_pkg::LANE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [kwsm_pkg::IN_TDATA_W-1:0]      in_data,
	input  logic                                 in_user,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [kwsm_pkg::OUT_TDATA_W-1:0]     out_data,
	output logic [kwsm_pkg::STATUS_W-1:0]        out_user,
	input  kwsm_pkg::cmd_t                       cmd,
	output kwsm_pkg::sts_t                       sts
);
	import kwsm_pkg::*;

	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int PTR_W  = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
	localparam int FILL_W = $clog2(LANE_DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(LANE_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LANE_DEPTH);
	localparam logic [LANE_W-1:0] IDX_LAST  = LANE_W'(LANES - 1);

	logic [VALUE_W-1:0]      mem_q [LANES][LANE_DEPTH];
	logic [PTR_W-1:0]        head_q [LANES];
	logic [PTR_W-1:0]        tail_q [LANES];
	logic [FILL_W-1:0]       fill_q [LANES];

	logic [LANE_FIELD_W-1:0] lane_q;
	logic [VALUE_W-1:0]      value_q;
	logic [LANE_W-1:0]       idx_q;

	logic                    vld_s1;
	logic                    nonempty_s1;
	logic [LANE_W-1:0]       lane_s1;
	logic [VALUE_W-1:0]      rd_s1;

	logic                    found_q;
	logic [VALUE_W-1:0]      best_q;
	logic [LANE_W-1:0]       best_lane_q;

	status_t                 res_status_q;
	logic [VALUE_W-1:0]      res_value_q;
	logic [LANE_FIELD_W-1:0] res_lane_q;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [VALUE_W-1:0]      out_value_q;
	logic [LANE_FIELD_W-1:0] out_lane_q;

	logic [LANE_W-1:0]       lane_idx;
	logic                    lane_ok;
	logic                    append_ok;
	logic                    do_pop;
	logic                    better;

	assign lane_idx  = LANE_W'(lane_q);
	assign lane_ok   = (32'(lane_q) < 32'(LANES));
	assign append_ok = cmd.append & lane_ok & (fill_q[lane_idx] != FILL_FULL);
	assign do_pop    = cmd.pop & found_q;
	assign better    = !found_q || ($signed(best_q) >= $signed(rd_s1));

	assign sts.opcode    = in_user;
	assign sts.scan_last = (idx_q == IDX_LAST);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_TDATA_W - VALUE_W - LANE_FIELD_W)'(0), out_lane_q, out_value_q};
	assign out_user  = out_status_q;

	// Hold the request payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lane_q  <= in_data[LANE_FIELD_W-1:0];
			value_q <= in_data[LANE_FIELD_W +: VALUE_W];
		end
	end

	// Lane storage: one write port for appends, one registered read for the scan.
	always_ff @(posedge clk) begin
		if (append_ok) begin
			mem_q[lane_idx][tail_q[lane_idx]] <= value_q;
		end
		if (cmd.scan) begin
			rd_s1 <= mem_q[idx_q][head_q[idx_q]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			lane_s1     <= idx_q;
			nonempty_s1 <= (fill_q[idx_q] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < LANES; i++) begin
				if (append_ok && (lane_idx == LANE_W'(i))) begin
					tail_q[i] <= (tail_q[i] == PTR_LAST) ? '0 : tail_q[i] + 1'b1;
					fill_q[i] <= fill_q[i] + 1'b1;
				end else if (do_pop && (best_lane_q == LANE_W'(i))) begin
					head_q[i] <= (head_q[i] == PTR_LAST) ? '0 : head_q[i] + 1'b1;
					fill_q[i] <= fill_q[i] - 1'b1;
				end
			end
		end
	end

	// Advance the scan and keep the smallest head; ties go to the later lane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan && !sts.scan_last) begin
					idx_q <= idx_q + 1'b1;
				end
				if (vld_s1 && nonempty_s1 && better) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && nonempty_s1 && better) begin
			best_q      <= rd_s1;
			best_lane_q <= lane_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			res_status_q <= append_ok ? ST_APPENDED : ST_FULL;
			res_value_q  <= '0;
			res_lane_q   <= '0;
		end else if (cmd.pop) begin
			if (found_q) begin
				res_status_q <= ST_EMITTED;
				res_value_q  <= best_q;
				res_lane_q   <= LANE_FIELD_W'(best_lane_q);
			end else begin
				res_status_q <= ST_EMPTY;
				res_value_q  <= '0;
				res_lane_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_lane_q   <= res_lane_q;
		end
	end

endmodule

[dv/kwsm_merge_checker.sv]
`timescale 1ns / 100ps
// Checker for the k-way sorted merge: mirrors the lanes, predicts each result and compares it.
module kwsm_merge_checker #(
	parameter int LANES = kwsm_pkg::LANES_DEF,
	parameter int DEPTH = kwsm_pkg::LANE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [kwsm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // lane[1:0], value[33:2]
	input  logic                             s_axis_tuser,  // opcode[0]
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [kwsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // out_value[31:0], source_lane[33:32]
	input  logic [kwsm_pkg::STATUS_W-1:0]    m_axis_tuser,  // status[1:0]
	output int                               mismatches,
	output int                               pending,
	output int                               emitted_cnt,
	output int                               empty_cnt,
	output int                               full_cnt
);
	import kwsm_pkg::*;

	typedef struct packed {
		status_t                 status;
		logic [VALUE_W-1:0]      value;
		logic [LANE_FIELD_W-1:0] src;
	} merge_result_t;

	logic [VALUE_W-1:0] lane_mem [LANES][DEPTH];
	int unsigned        lane_head [LANES];
	int unsigned        lane_fill [LANES];
	merge_result_t      merge_q [$];
	int                 err_n   = 0;
	int                 emit_n  = 0;
	int                 empty_n = 0;
	int                 full_n  = 0;

	function automatic merge_result_t merge_predict(input logic op, input int unsigned ln,
			input logic [VALUE_W-1:0] val);
		merge_result_t r;
		bit            found;
		int unsigned   best;
		r     = '0;
		found = 1'b0;
		best  = 0;
		if (op == OP_APPEND) begin
			if (ln >= LANES || lane_fill[ln] >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				lane_mem[ln][(lane_head[ln] + lane_fill[ln]) % DEPTH] = val;
				lane_fill[ln]++;
				r.status = ST_APPENDED;
			end
		end else begin
			// ties go to the higher lane
			for (int i = 0; i < LANES; i++) begin
				if (lane_fill[i] != 0 && (!found || $signed(lane_mem[best][lane_head[best]]) >=
						$signed(lane_mem[i][lane_head[i]]))) begin
					best  = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				r.status = ST_EMPTY;
			end else begin
				r.status        = ST_EMITTED;
				r.value         = lane_mem[best][lane_head[best]];
				r.src           = best[LANE_FIELD_W-1:0];
				lane_head[best] = (lane_head[best] + 1) % DEPTH;
				lane_fill[best]--;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		merge_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				lane_head[i] = 0;
				lane_fill[i] = 0;
			end
			merge_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (merge_q.size() == 0) begin
					err_n++;
					$display("%0t: unexpected result, expected none, %s %0d value %h lane %0d",
						$time, "actual status", m_axis_tuser, m_axis_tdata[VALUE_W-1:0],
						m_axis_tdata[VALUE_W +: LANE_FIELD_W]);
				end else begin
					exp_r = merge_q.pop_front();
					if (m_axis_tuser != exp_r.status) begin
						err_n++;
						$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
							m_axis_tuser);
					end
					if (m_axis_tdata[VALUE_W-1:0] != exp_r.value) begin
						err_n++;
						$display("%0t: out_value expected %h actual %h", $time, exp_r.value,
							m_axis_tdata[VALUE_W-1:0]);
					end
					if (m_axis_tdata[VALUE_W +: LANE_FIELD_W] != exp_r.src) begin
						err_n++;
						$display("%0t: source_lane expected %0d actual %0d", $time, exp_r.src,
							m_axis_tdata[VALUE_W +: LANE_FIELD_W]);
					end
					unique case (exp_r.status)
						ST_EMITTED: emit_n++;
						ST_EMPTY:   empty_n++;
						ST_FULL:    full_n++;
						default: ;
					endcase
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				merge_q.insert(merge_q.size(), merge_predict(s_axis_tuser,
					32'(s_axis_tdata[LANE_FIELD_W-1:0]),
					s_axis_tdata[LANE_FIELD_W +: VALUE_W]));
			end
		end
		mismatches  <= err_n;
		pending     <= merge_q.size();
		emitted_cnt <= emit_n;
		empty_cnt   <= empty_n;
		full_cnt    <= full_n;
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the k-way sorted merge: clock, reset, request stimulus and verdict.
module tb;
	import kwsm_pkg::*;

	localparam int LANES       = LANES_DEF;
	localparam int LANE_DEPTH  = LANE_DEPTH_DEF;
	localparam int N_REQUESTS  = 1500;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tuser  = OP_APPEND;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]    m_axis_tuser;

	int mismatches, pending, emitted_cnt, empty_cnt, full_cnt;
	int req_count    = 0;
	int stuck_cycles = 0;
	bit quiet        = 1'b0;
	bit hold_req     = 1'b0;

	logic signed [VALUE_W-1:0] lane_last [4] = '{default: 32'sh8000_0000};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	k_way_sorted_merge #(
		.LANES      (LANES),
		.LANE_DEPTH (LANE_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	kwsm_merge_checker #(
		.LANES (LANES),
		.DEPTH (LANE_DEPTH)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.pending       (pending),
		.emitted_cnt   (emitted_cnt),
		.empty_cnt     (empty_cnt),
		.full_cnt      (full_cnt)
	);

	task automatic send_request(input logic op, input logic [LANE_FIELD_W-1:0] ln,
			input logic [VALUE_W-1:0] val);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{(IN_TDATA_W - VALUE_W - LANE_FIELD_W){1'b0}}, val, ln};
		do @(posedge clk); while (!s_axis_tready);
		req_count++;
	endtask

	task automatic send_mixed(input int n, input int append_pct);
		logic [LANE_FIELD_W-1:0] ln;
		logic [VALUE_W-1:0]      val;
		longint                  nxt;
		for (int k = 0; k < n; k++) begin
			ln = LANE_FIELD_W'($urandom_range(0, 3));
			if ($urandom_range(0, 99) < append_pct) begin
				if ($urandom_range(0, 9) == 0) begin
					val = $urandom();
				end else begin
					// keep each lane ascending; restart low on overflow
					nxt = longint'(lane_last[ln]) +
						longint'($urandom_range(0, 1 << $urandom_range(0, 26)));
					if (nxt > longint'(32'sh7fff_ffff))
						nxt = longint'(32'sh8000_0000) + longint'($urandom_range(0, 255));
					val           = nxt[VALUE_W-1:0];
					lane_last[ln] = val;
				end
				send_request(OP_APPEND, ln, val);
			end else begin
				send_request(OP_TAKE, LANE_FIELD_W'($urandom()), $urandom());
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		int wait_cycles;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				wait_cycles = HOLD_CYCLES;
				hold_req    = 1'b0;
			end else begin
				wait_cycles = quiet ? 0 : $urandom_range(0, 18);
			end
			if (wait_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		send_request(OP_TAKE, 2'd0, '0);
		for (int i = 0; i < LANE_DEPTH; i++) begin
			send_request(OP_APPEND, 2'd2, (i == 0) ? 32'h8000_0000 :
				(i == LANE_DEPTH - 1) ? 32'h7fff_ffff : 32'(i * 1000 - 7000));
		end
		send_request(OP_APPEND, 2'd2, 32'd1);
		send_request(OP_APPEND, 2'd0, 32'h8000_0000);
		send_request(OP_APPEND, 2'd3, 32'h7fff_ffff);
		send_request(OP_APPEND, 2'd1, 32'hffff_ffff);
		send_request(OP_TAKE, 2'd3, 32'hffff_ffff);
		send_request(OP_TAKE, 2'd1, 32'h0000_0000);
		hold_req = 1'b1;
		while (req_count < N_REQUESTS) begin
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0:       send_mixed(40, 25);
				1:       send_mixed(40, 55);
				default: send_mixed(40, 85);
			endcase
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LANES + 20) @(posedge clk);
		$display("tb: %0d requests driven; %0d values merged out, %0d empty takes, %0d drops on full lanes",
			req_count, emitted_cnt, empty_cnt, full_cnt);
		$display("tb: signed extremes, ties, unsorted feeds and a %0d-cycle output hold-off covered",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
